[rtl/exp_map_rotation_reparameterize_defines.svh]
// Assertion helpers used by the block's top-level RTL.
`ifndef EXP_MAP_ROTATION_REPARAMETERIZE_DEFINES_SVH
`define EXP_MAP_ROTATION_REPARAMETERIZE_DEFINES_SVH

// Checked outside reset.
`define EMR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define EMR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/emr_pkg.sv]
package emr_pkg;

  localparam int unsigned ROT_W   = 32;
  localparam int unsigned SQ_W    = 64;
  localparam int unsigned NORM_W  = 32;
  localparam int unsigned F_W     = 27;
  localparam int unsigned PROD_W  = 59;
  localparam int unsigned SNUM_W  = 60;
  localparam int unsigned H_W     = 24;
  localparam int unsigned DMAG_W  = 29;
  localparam int unsigned VEL_SHIFT = 20;
  localparam int unsigned VNUM_W  = DMAG_W + VEL_SHIFT;
  localparam int unsigned VQ_W    = 32;

  localparam logic [F_W-1:0] TWO_PI = 27'd105414357;
  localparam logic [F_W-1:0] PI_Q   = 27'd52707179;

  localparam logic [ROT_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
  localparam logic [ROT_W-1:0] VEL_MIN = 32'h8000_0000;

  localparam logic             REG_TIME_STEP = 1'b0;
  localparam logic [H_W-1:0]   TIME_STEP_RST = 24'd167772;

  function automatic logic [ROT_W-1:0] abs32(input logic [ROT_W-1:0] v);
    abs32 = v[ROT_W-1] ? (~v + 32'd1) : v;
  endfunction

  // one compare-subtract of a whole-turn reduction, turn count bit k
  function automatic logic [NORM_W-1:0] red_step(input logic [NORM_W-1:0] t,
                                                 input int unsigned k);
    logic [NORM_W:0] m;
    m = 33'(TWO_PI) << k;
    if ({1'b0, t} >= m) begin
      red_step = NORM_W'({1'b0, t} - m);
    end else begin
      red_step = t;
    end
  endfunction

endpackage

[rtl/exp_map_rotation_reparameterize.sv]
// Throughput: one item per cycle; the whole pipeline advances when the
// output register is empty or taken. Depth is set by the 32-stage square
// root, the 27-stage scaling divider and the 32-stage velocity divider.
// Reset (synchronous): clears all valid bits, time_step returns to 167772.
`include "exp_map_rotation_reparameterize_defines.svh"

module exp_map_rotation_reparameterize (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // prev_rot_x/y/z, cur_rot_x/y/z, ang_vel_x/y/z, 32 bits each from bit 0
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_prev_x/y/z, new_cur_x/y/z, new_vel_x/y/z, 32 bits each from bit 0
  output logic [287:0] m_tdata,
  // flipped
  output logic         m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int ST_SUM   = 2;
  localparam int ST_THETA = ST_SUM + emr_pkg::NORM_W;
  localparam int ST_RED   = ST_THETA + 3;
  localparam int ST_F     = ST_RED + 1;
  localparam int ST_MUL   = ST_F + 1;
  localparam int ST_NUM   = ST_MUL + 1;
  localparam int ST_Q     = ST_NUM + emr_pkg::F_W;
  localparam int ST_SGN   = ST_Q + 1;
  localparam int ST_D     = ST_SGN + 1;
  localparam int ST_VIN   = ST_D + 1;
  localparam int ST_VQ    = ST_VIN + emr_pkg::VQ_W;
  localparam int LAT      = ST_VQ + 1;

  // config register
  logic [emr_pkg::H_W-1:0] time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= emr_pkg::TIME_STEP_RST;
    end else if (psel && penable && pwrite && paddr[2] == emr_pkg::REG_TIME_STEP) begin
      time_step <= pwdata[emr_pkg::H_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == emr_pkg::REG_TIME_STEP) ? 32'(time_step) : '0;

  // pipeline control
  logic [LAT-1:0] vp;
  logic           adv;

  assign adv      = !vp[LAT-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vp[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (adv) begin
      vp <= {vp[LAT-2:0], s_tvalid};
    end
  end

  // payload
  logic [5:0][31:0] rot_in;
  logic [2:0][31:0] vel_in;

  assign rot_in = s_tdata[191:0];
  assign vel_in = s_tdata[287:192];

  logic [5:0][emr_pkg::SQ_W-1:0]   sq;
  logic [1:0][emr_pkg::SQ_W-1:0]   sum;
  logic [1:0][emr_pkg::NORM_W-1:0] theta;
  logic [1:0][emr_pkg::NORM_W-1:0] t1, t2, t3;
  logic [1:0]                      z1, z2, z3, z38;
  logic [1:0][emr_pkg::F_W-1:0]    rv;
  logic [1:0][emr_pkg::F_W-1:0]    fm;
  logic                            flip_c, flip38;
  logic [5:0][31:0]                rot38;
  logic [1:0][emr_pkg::NORM_W-1:0] theta39;
  logic [5:0][emr_pkg::PROD_W-1:0] prod;
  logic [5:0][emr_pkg::SNUM_W-1:0] num;
  logic [1:0][emr_pkg::NORM_W-1:0] den40;
  logic [194:0]                    b38, b67;
  logic [1:0]                      z67;
  logic                            flip67;
  logic [5:0][31:0]                rot67;
  logic [5:0][emr_pkg::F_W-1:0]    q67;
  logic [5:0][31:0]                nv68, nv69, nv70, nv102;
  logic                            flip68, flip69, flip70, flip102;
  logic [2:0][emr_pkg::DMAG_W-1:0] dmag69;
  logic [2:0]                      dneg69, dzero69;
  logic [2:0][emr_pkg::VNUM_W-1:0] vnum70;
  logic [2:0]                      vneg70, vsat70, vzero70;
  logic [2:0]                      vneg102, vsat102, vzero102;
  logic [emr_pkg::H_W-1:0]         hd70;
  logic [201:0]                    b70, b102;
  logic [2:0][31:0]                vel102;
  logic [2:0][emr_pkg::VQ_W-1:0]   vq102;
  logic [5:0][31:0]                orot;
  logic [2:0][31:0]                ovel;
  logic                            oflip;

  // squares and norms
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 6; k++) begin
        sq[k] <= {32'b0, emr_pkg::abs32(rot_in[k])} * {32'b0, emr_pkg::abs32(rot_in[k])};
      end
      for (int g = 0; g < 2; g++) begin
        sum[g] <= sq[3*g] + sq[3*g+1] + sq[3*g+2];
      end
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_norm
    emr_isqrt u_sqrt (
      .clk  (clk),
      .en   (adv),
      .x    (sum[g]),
      .root (theta[g])
    );
  end

  // whole-turn reduction, two turn-count bits per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < 2; g++) begin
        t1[g] <= emr_pkg::red_step(emr_pkg::red_step(theta[g] - 32'd1, 5), 4);
        z1[g] <= theta[g] == '0;
        t2[g] <= emr_pkg::red_step(emr_pkg::red_step(t1[g], 3), 2);
        t3[g] <= emr_pkg::red_step(emr_pkg::red_step(t2[g], 1), 0);
      end
      z2 <= z1;
      z3 <= z2;
    end
  end

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      rv[g] = z3[g] ? '0 : emr_pkg::F_W'(t3[g] + 32'd1);
    end
    flip_c = (rv[0] > emr_pkg::PI_Q) && (rv[1] > emr_pkg::PI_Q);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < 2; g++) begin
        fm[g] <= flip_c ? emr_pkg::TWO_PI - rv[g] : rv[g];
      end
      flip38 <= flip_c;
      z38    <= z3;
    end
  end

  emr_delay #(.W(192), .DEPTH(ST_F)) u_rot_dly (
    .clk (clk), .en (adv), .d (rot_in), .q (rot38)
  );

  emr_delay #(.W(64), .DEPTH(ST_MUL - ST_THETA)) u_theta_dly (
    .clk (clk), .en (adv), .d (theta), .q (theta39)
  );

  assign b38 = {z38, flip38, rot38};
  assign {z67, flip67, rot67} = b67;

  emr_delay #(.W(195), .DEPTH(ST_Q - ST_F)) u_side_dly (
    .clk (clk), .en (adv), .d (b38), .q (b67)
  );

  // scaling by f / theta
  for (genvar k = 0; k < 6; k++) begin : g_scale
    localparam int G = k / 3;
    logic [31:0] qx;

    always_ff @(posedge clk) begin
      if (adv) begin
        prod[k] <= emr_pkg::PROD_W'(emr_pkg::abs32(rot38[k])) * emr_pkg::PROD_W'(fm[G]);
        num[k]  <= emr_pkg::SNUM_W'(prod[k]) + emr_pkg::SNUM_W'(theta39[G] >> 1);
      end
    end

    emr_div #(
      .NUM_W (emr_pkg::SNUM_W),
      .DEN_W (emr_pkg::NORM_W),
      .QUO_W (emr_pkg::F_W)
    ) u_div (
      .clk (clk),
      .en  (adv),
      .num (num[k]),
      .den (den40[G]),
      .quo (q67[k])
    );

    assign qx = 32'(q67[k]);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (z67[G]) begin
          nv68[k] <= rot67[k];
        end else if (rot67[k][31] ^ flip67) begin
          nv68[k] <= ~qx + 32'd1;
        end else begin
          nv68[k] <= qx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den40  <= theta39;
      flip68 <= flip67;
      flip69 <= flip68;
      flip70 <= flip69;
      nv69   <= nv68;
      nv70   <= nv69;
      hd70   <= time_step;
    end
  end

  // velocity from the new vectors
  for (genvar i = 0; i < 3; i++) begin : g_vel
    logic [32:0]                cp, pc;
    logic [emr_pkg::VNUM_W-1:0] vn;

    assign cp = {nv68[3+i][31], nv68[3+i]} - {nv68[i][31], nv68[i]};
    assign pc = {nv68[i][31], nv68[i]} - {nv68[3+i][31], nv68[3+i]};
    assign vn = {dmag69[i], 20'b0} + emr_pkg::VNUM_W'(time_step >> 1);

    always_ff @(posedge clk) begin
      if (adv) begin
        dneg69[i]  <= cp[32];
        dzero69[i] <= cp == '0;
        dmag69[i]  <= cp[32] ? emr_pkg::DMAG_W'(pc) : emr_pkg::DMAG_W'(cp);
        vnum70[i]  <= vn;
        vneg70[i]  <= dneg69[i];
        vzero70[i] <= dzero69[i];
        vsat70[i]  <= !dzero69[i] && ({7'b0, vn} >= {time_step, 32'b0});
      end
    end

    emr_div #(
      .NUM_W (emr_pkg::VNUM_W),
      .DEN_W (emr_pkg::H_W),
      .QUO_W (emr_pkg::VQ_W)
    ) u_vdiv (
      .clk (clk),
      .en  (adv),
      .num (vnum70[i]),
      .den (hd70),
      .quo (vq102[i])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        priority if (!flip102) begin
          ovel[i] <= vel102[i];
        end else if (vzero102[i]) begin
          ovel[i] <= '0;
        end else if (vsat102[i]) begin
          ovel[i] <= vneg102[i] ? emr_pkg::VEL_MIN : emr_pkg::VEL_MAX;
        end else if (vneg102[i]) begin
          ovel[i] <= (vq102[i] > emr_pkg::VEL_MIN) ? emr_pkg::VEL_MIN : ~vq102[i] + 32'd1;
        end else begin
          ovel[i] <= vq102[i][31] ? emr_pkg::VEL_MAX : vq102[i];
        end
      end
    end
  end

  assign b70 = {nv70, flip70, vneg70, vsat70, vzero70};
  assign {nv102, flip102, vneg102, vsat102, vzero102} = b102;

  emr_delay #(.W(202), .DEPTH(ST_VQ - ST_VIN)) u_vel_side_dly (
    .clk (clk), .en (adv), .d (b70), .q (b102)
  );

  emr_delay #(.W(96), .DEPTH(ST_VQ)) u_w_dly (
    .clk (clk), .en (adv), .d (vel_in), .q (vel102)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      orot  <= nv102;
      oflip <= flip102;
    end
  end

  assign m_tdata = {ovel, orot};
  assign m_tuser = oflip;

  `EMR_ASSERT(a_fold_range, vp[ST_F-1] |-> (fm[0] <= emr_pkg::TWO_PI) && (fm[1] <= emr_pkg::TWO_PI), "scale factor above one turn")
  `EMR_ASSERT(a_flip_short, vp[ST_F-1] && flip38 |-> (fm[0] <= emr_pkg::PI_Q) && (fm[1] <= emr_pkg::PI_Q), "flipped factor above pi")
  `EMR_ASSERT(a_stall_hold, !adv |=> $stable(vp), "valid bits moved during stall")
  `EMR_ASSERT_ALWAYS(a_reset_clear, $past(rst) |-> (vp == '0), "valid bits not cleared by reset")

endmodule

[rtl/emr_delay.sv]
module emr_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

[rtl/emr_isqrt.sv]
// floor square root, two radicand bits per stage
module emr_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [emr_pkg::SQ_W-1:0]    x,
  output logic [emr_pkg::NORM_W-1:0]  root
);

  localparam int N  = emr_pkg::NORM_W;
  localparam int XW = emr_pkg::SQ_W;
  localparam int RW = N + 2;

  logic [RW-1:0] rem_s  [N];
  logic [N-1:0]  root_s [N];
  logic [XW-1:0] xs_s   [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [RW-1:0] rem_i;
    logic [N-1:0]  root_i;
    logic [XW-1:0] xs_i;
    logic [RW+1:0] trem;
    logic [RW+1:0] trial;

    if (i == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign xs_i   = x;
    end else begin : g_next
      assign rem_i  = rem_s[i-1];
      assign root_i = root_s[i-1];
      assign xs_i   = xs_s[i-1];
    end

    assign trem  = {rem_i, xs_i[XW-1 -: 2]};
    assign trial = {2'b00, root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trem >= trial) begin
          rem_s[i]  <= RW'(trem - trial);
          root_s[i] <= {root_i[N-2:0], 1'b1};
        end else begin
          rem_s[i]  <= RW'(trem);
          root_s[i] <= {root_i[N-2:0], 1'b0};
        end
        xs_s[i] <= {xs_i[XW-3:0], 2'b00};
      end
    end
  end

  assign root = root_s[N-1];

endmodule

[rtl/emr_div.sv]
// restoring divider, one quotient bit per stage; needs num < den * 2**QUO_W
module emr_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 32,
  parameter int QUO_W = 27
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [DEN_W-1:0] rem_s [QUO_W];
  logic [QUO_W-1:0] lq_s  [QUO_W];
  logic [DEN_W-1:0] den_s [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_st
    logic [DEN_W-1:0] rem_i;
    logic [QUO_W-1:0] lq_i;
    logic [DEN_W-1:0] den_i;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_i = DEN_W'(num >> QUO_W);
      assign lq_i  = num[QUO_W-1:0];
      assign den_i = den;
    end else begin : g_next
      assign rem_i = rem_s[i-1];
      assign lq_i  = lq_s[i-1];
      assign den_i = den_s[i-1];
    end

    assign trial = {rem_i, lq_i[QUO_W-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lq_s[i]  <= {lq_i[QUO_W-2:0], ge};
        den_s[i] <= den_i;
      end
    end
  end

  assign quo = lq_s[QUO_W-1];

endmodule

[tb/tb_top.sv]
module tb_top;

  localparam longint TWO_PI_Q = 105414357;
  localparam longint PI_Q24 = 52707179;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] vz, vy, vx, cz, cy, cx, pz, py, px;
  } body_t;

  typedef struct {
    logic [287:0] data;
    logic         flip;
  } reparam_t;

  typedef struct {
    body_t    body;
    logic     has_exp;
    reparam_t exp_res;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [287:0] m_tdata;
  logic         m_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  exp_map_rotation_reparameterize u_dut (.*);

  always #6 clk = ~clk;

  reparam_t  pending_q[$];
  int        errors = 0;
  int        cycles = 0;
  logic      calm = 1'b0;
  logic      sink_busy = 1'b1;
  logic [23:0] step_h;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic longint isqrt(input logic [65:0] s);
    longint unsigned r;
    logic [65:0] rem;
    logic [65:0] bit_v;
    rem = s;
    r = 0;
    bit_v = 66'd1 << 64;
    while (bit_v > rem) bit_v >>= 2;
    while (bit_v != 0) begin
      if (rem >= r + bit_v) begin
        rem -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  function automatic longint rdiv_sat(input logic [127:0] mag, input logic neg,
                                      input longint den);
    logic [127:0] q;
    q = (mag + den / 2) / den;
    if (neg) return (q > 128'h8000_0000) ? -64'sh8000_0000 : -longint'(q);
    return (q > 128'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
  endfunction

  function automatic void rescale(inout longint v[3], input longint f, input longint th);
    for (int i = 0; i < 3; i++)
      v[i] = rdiv_sat((v[i] < 0 ? -v[i] : v[i]) * (f < 0 ? -f : f),
                      (v[i] < 0) != (f < 0), th);
  endfunction

  function automatic reparam_t predict_reparam(input body_t b);
    longint p[3], c[3], w[3], th0, th1, r0, r1, d;
    logic flip;
    reparam_t res;
    p = '{signed'(b.px), signed'(b.py), signed'(b.pz)};
    c = '{signed'(b.cx), signed'(b.cy), signed'(b.cz)};
    w = '{signed'(b.vx), signed'(b.vy), signed'(b.vz)};
    th0 = isqrt(66'(p[0]*p[0]) + 66'(p[1]*p[1]) + 66'(p[2]*p[2]));
    th1 = isqrt(66'(c[0]*c[0]) + 66'(c[1]*c[1]) + 66'(c[2]*c[2]));
    r0 = th0 == 0 ? 0 : th0 - ((th0 - 1) / TWO_PI_Q) * TWO_PI_Q;
    r1 = th1 == 0 ? 0 : th1 - ((th1 - 1) / TWO_PI_Q) * TWO_PI_Q;
    flip = (r0 > PI_Q24) && (r1 > PI_Q24);
    if (th0 != 0) rescale(p, flip ? r0 - TWO_PI_Q : r0, th0);
    if (th1 != 0) rescale(c, flip ? r1 - TWO_PI_Q : r1, th1);
    if (flip) begin
      for (int i = 0; i < 3; i++) begin
        d = c[i] - p[i];
        if (d == 0) w[i] = 0;
        else if (step_h == 0) w[i] = d < 0 ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
        else w[i] = rdiv_sat(128'(d < 0 ? -d : d) << 20, d < 0, step_h);
      end
    end
    res.data = {w[2][31:0], w[1][31:0], w[0][31:0], c[2][31:0], c[1][31:0],
                c[0][31:0], p[2][31:0], p[1][31:0], p[0][31:0]};
    res.flip = flip;
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    reparam_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_q.size() == 0) begin
          report("unexpected item", m_tdata[31:0], 32'd0);
        end else begin
          want = pending_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_tdata[32*i +: 32] !== want.data[32*i +: 32])
              report($sformatf("field %0d", i), m_tdata[32*i +: 32], want.data[32*i +: 32]);
          if (m_tuser !== want.flip) report("flipped", 32'(m_tuser), 32'(want.flip));
        end
      end
      m_tready <= sink_busy ? 1'b0 : (calm || $urandom_range(99) >= 33);
    end
  end

  task automatic apb_write(input logic [23:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {8'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    step_h = v;
  endtask

  task automatic send_body(input body_t b);
    while (!calm && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    pending_q.push_back(predict_reparam(b));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_comp(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 120000000)) - 60000000);
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return {{4{1'($urandom_range(1))}}, 28'($urandom())};
    endcase
  endfunction

  function automatic body_t on_axis(input logic [31:0] pv, input logic [31:0] cv,
                                    input logic [31:0] vv);
    body_t b;
    b = '0;
    b.px = pv; b.cx = cv; b.vx = vv; b.vy = 32'h7FFF_FFFF; b.vz = 32'h8000_0000;
    return b;
  endfunction

  stim_row_t rows[$];
  stim_row_t row;
  body_t b;
  int mode;
  logic [23:0] steps[4] = '{24'd167772, 24'd1, 24'hFFFFFF, 24'd0};

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    sink_busy = 1'b0;
    step_h = emr_pkg::TIME_STEP_RST;
    @(posedge clk);

    row.has_exp = 1'b1;
    row.body = '0;
    row.exp_res.data = '0; row.exp_res.flip = 1'b0;
    rows.push_back(row);
    row.body = on_axis(32'h0100_0000, 32'h0200_0000, 32'h1234_5678);
    row.exp_res.data = row.body; row.exp_res.flip = 1'b0;
    rows.push_back(row);
    row.has_exp = 1'b0;
    rows.push_back('{on_axis(32'h0400_0000, 32'h0500_0000, 32'h1), 1'b0, row.exp_res});
    rows.push_back('{on_axis(32'(TWO_PI_Q), 32'(TWO_PI_Q * 2), 32'h5), 1'b0, row.exp_res});
    rows.push_back('{on_axis(32'h8000_0000, 32'h7FFF_FFFF, 32'h0), 1'b0, row.exp_res});
    rows.push_back('{on_axis(32'h7FFF_FFFF, 32'h8000_0000, 32'h0), 1'b0, row.exp_res});
    rows.push_back('{on_axis(32'hFC00_0000, 32'h0400_0000, 32'h7), 1'b0, row.exp_res});
    rows.push_back('{on_axis(32'(PI_Q24), 32'(PI_Q24 + 1), 32'h9), 1'b0, row.exp_res});
    rows.push_back('{on_axis(32'(PI_Q24 + 1), 32'(PI_Q24 + 1), 32'h9), 1'b0, row.exp_res});
    rows.push_back('{on_axis(32'h0000_0001, 32'hFFFF_FFFF, 32'h3), 1'b0, row.exp_res});
    rows.push_back('{'{default: 32'h8000_0000}, 1'b0, row.exp_res});
    rows.push_back('{'{default: 32'h7FFF_FFFF}, 1'b0, row.exp_res});
    rows.push_back('{'{default: 32'hFFFF_FFFF}, 1'b0, row.exp_res});

    foreach (steps[k]) begin
      drain();
      apb_write(steps[k]);
      foreach (rows[i]) begin
        if (rows[i].has_exp) pending_q.push_back(rows[i].exp_res);
        send_body(rows[i].body);
        if (rows[i].has_exp) void'(pending_q.pop_back());
      end
    end

    for (int n = 0; n < 1250; n++) begin
      if (n % 300 == 0) begin
        drain();
        apb_write(n == 600 ? 24'd0 : 24'($urandom_range(1, 24'hFFFFFF)));
      end
      calm = (n >= 700 && n < 850);
      mode = $urandom_range(3);
      for (int j = 0; j < 9; j++) b[32*j +: 32] = rnd_comp(j >= 6 ? 0 : mode);
      if ($urandom_range(9) == 0) begin
        b.px = 32'(PI_Q24 + $urandom_range(32'(TWO_PI_Q - PI_Q24))); b.py = 0; b.pz = 0;
        b.cx = 32'(-(PI_Q24 + $urandom_range(32'(TWO_PI_Q - PI_Q24)))); b.cy = 0; b.cz = 0;
      end
      send_body(b);
    end
    calm = 1'b0;
    drain();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/emr_pkg.sv
rtl/emr_delay.sv
rtl/emr_isqrt.sv
rtl/emr_div.sv
rtl/exp_map_rotation_reparameterize.sv
tb/tb_top.sv
